>>> sv/rqd_pkg.sv
// Shared types and codes for the request queue with duplicate suppression.
// No dependencies; compiled first.
package rqd_pkg;

   // Command codes
   localparam logic [2:0] CMD_REGISTER   = 3'd0;
   localparam logic [2:0] CMD_PUT        = 3'd1;
   localparam logic [2:0] CMD_PUT_UNIQUE = 3'd2;
   localparam logic [2:0] CMD_TAKE       = 3'd3;
   localparam logic [2:0] CMD_FINISH     = 3'd4;
   localparam logic [2:0] CMD_REMOVE     = 3'd5;
   localparam logic [2:0] CMD_COUNT      = 3'd6;

   // Status codes
   localparam logic [2:0] ST_OK          = 3'd0;
   localparam logic [2:0] ST_BAD_HANDLER = 3'd1;
   localparam logic [2:0] ST_TOO_MANY    = 3'd2;
   localparam logic [2:0] ST_DUPLICATE   = 3'd3;
   localparam logic [2:0] ST_BLOCKED     = 3'd4;

   localparam int ITEM_W = 5;

   typedef struct packed {
      logic [2:0]  command;
      logic [7:0]  req_type;
      logic [31:0] data_tag;
      logic        handler_valid;
   } req_item_type;

   typedef struct packed {
      logic [2:0]        status;
      logic              entry_valid;
      logic [7:0]        entry_type;
      logic [31:0]       entry_data;
      logic [ITEM_W-1:0] item_count;
      logic              pending;
      logic              last;
   } rsp_item_type;

   // One queue entry as stored in memory
   typedef struct packed {
      logic [7:0]  etype;
      logic [31:0] tag;
   } q_entry_type;

endpackage

>>> sv/rqd_req_if.sv
// Request channel interface: valid/ready handshake carrying one command.
// Depends on rqd_pkg.
interface rqd_req_if;
   import rqd_pkg::*;
   logic         valid;
   logic         ready;
   req_item_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

>>> sv/rqd_rsp_if.sv
// Response channel interface: valid/ready handshake carrying one result.
// Depends on rqd_pkg.
interface rqd_rsp_if;
   import rqd_pkg::*;
   logic         valid;
   logic         ready;
   rsp_item_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

>>> sv/request_queue_with_dedup_unit.sv
// Top level: request queue with type table, dedup and remove-by-type.
// Depends on rqd_pkg, rqd_req_if, rqd_rsp_if.
//
//  channel   | dir | handshake          | carries
//  ----------+-----+--------------------+-------------------------------
//  req_chan  | in  | valid & ready      | command, type, tag, handler
//  rsp_chan  | out | valid & ready      | status, entry, count, flags
//  csr_*     | in  | csr_wr_en          | blocked bit
//
// One transaction at a time. Queue and type table live in single-port-read
// memories, scanned one entry at a time: address, then compare.
// Synchronous active-high reset clears control state; memories hold garbage
// until written. A stalled response holds the engine only when it must emit.
module request_queue_with_dedup_unit #(
   parameter int QUEUE_DEPTH = 16,
   parameter int TYPE_SLOTS  = 8
) (
   input  logic  clock,
   input  logic  reset,
   rqd_req_if.sink   req_chan,
   rqd_rsp_if.source rsp_chan,
   input  logic  csr_wr_en,
   input  logic  csr_wr_data
);
   import rqd_pkg::*;

   localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int LW  = $clog2(QUEUE_DEPTH + 1);
   localparam int KAW = (TYPE_SLOTS > 1) ? $clog2(TYPE_SLOTS) : 1;
   localparam int KCW = $clog2(TYPE_SLOTS + 1);

   typedef enum logic [3:0] {
      S_IDLE, S_DECODE, S_KRD, S_KCHK, S_QRD, S_QCHK, S_PUSH,
      S_TAKE_RD, S_TAKE, S_CRD, S_CCHK, S_CEND, S_RRD, S_RCHK
   } state_type;

   function automatic logic [QAW-1:0] ptr_inc(input logic [QAW-1:0] p);
      if (p == QAW'(QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return p + 1'b1;
   endfunction

   // Memories
   q_entry_type q_mem [QUEUE_DEPTH];
   logic [7:0]  kt_mem [TYPE_SLOTS];
   q_entry_type q_rdata_ff;
   logic [7:0]  kt_rdata_ff;
   logic        q_we, kt_we;
   logic [QAW-1:0] q_waddr;
   q_entry_type q_wdata;

   // Control and state registers
   state_type    state_ff, state_in;
   req_item_type cmd_ff, cmd_in;
   logic [QAW-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [QAW-1:0] rptr_ff, rptr_in, wptr_ff, wptr_in;
   logic [LW-1:0]  len_ff, len_in, idx_ff, idx_in;
   logic [LW-1:0]  nrem_ff, nrem_in, ecnt_ff, ecnt_in;
   logic [KCW-1:0] kcnt_ff, kcnt_in, kidx_ff, kidx_in;
   logic         act_valid_ff, act_valid_in;
   q_entry_type  act_ff, act_in;
   logic         pending_ff, pending_in;
   logic         blocked_ff;
   logic         rsp_valid_ff;
   rsp_item_type rsp_ff;

   logic         emit_go, can_emit;
   rsp_item_type emit_d;

   assign can_emit       = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == S_IDLE);
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

   // Memory ports: registered read, one write each
   always_ff @(posedge clock) begin
      if (q_we) begin
         q_mem[q_waddr] <= q_wdata;
      end
      if (kt_we) begin
         kt_mem[kcnt_ff[KAW-1:0]] <= cmd_ff.req_type;
      end
      q_rdata_ff  <= q_mem[rptr_ff];
      kt_rdata_ff <= kt_mem[kidx_ff[KAW-1:0]];
   end

   // Command sequencer
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      rptr_in      = rptr_ff;
      wptr_in      = wptr_ff;
      len_in       = len_ff;
      idx_in       = idx_ff;
      nrem_in      = nrem_ff;
      ecnt_in      = ecnt_ff;
      kcnt_in      = kcnt_ff;
      kidx_in      = kidx_ff;
      act_valid_in = act_valid_ff;
      act_in       = act_ff;
      pending_in   = pending_ff;
      q_we         = 1'b0;
      q_waddr      = tail_ff;
      q_wdata      = '{etype: cmd_ff.req_type, tag: cmd_ff.data_tag};
      kt_we        = 1'b0;
      emit_go      = 1'b0;
      emit_d       = '0;
      emit_d.last  = 1'b1;

      case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               cmd_in   = req_chan.payload;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            kidx_in = '0;
            idx_in  = '0;
            nrem_in = '0;
            ecnt_in = '0;
            rptr_in = head_ff;
            wptr_in = head_ff;
            case (cmd_ff.command)
               CMD_REGISTER: begin
                  if (!cmd_ff.handler_valid) begin
                     emit_d.status = ST_BAD_HANDLER;
                     emit_go = can_emit;
                     if (can_emit) state_in = S_IDLE;
                  end else if (kcnt_ff >= KCW'(TYPE_SLOTS)) begin
                     emit_d.status = ST_TOO_MANY;
                     emit_go = can_emit;
                     if (can_emit) state_in = S_IDLE;
                  end else begin
                     state_in = S_KRD;
                  end
               end
               CMD_PUT, CMD_PUT_UNIQUE: begin
                  if (blocked_ff) begin
                     emit_d.status = ST_BLOCKED;
                     emit_go = can_emit;
                     if (can_emit) state_in = S_IDLE;
                  end else begin
                     state_in = S_KRD;
                  end
               end
               CMD_TAKE: begin
                  if (len_ff == '0) begin
                     if (can_emit) begin
                        pending_in = 1'b0;
                        emit_go    = 1'b1;
                        state_in   = S_IDLE;
                     end
                  end else begin
                     state_in = S_TAKE_RD;
                  end
               end
               CMD_FINISH: begin
                  if (can_emit) begin
                     act_valid_in = 1'b0;
                     act_in       = '0;
                     emit_go      = 1'b1;
                     state_in     = S_IDLE;
                  end
               end
               CMD_REMOVE: begin
                  state_in = S_CRD;
               end
               CMD_COUNT: begin
                  emit_d.item_count = ITEM_W'(len_ff);
                  emit_go = can_emit;
                  if (can_emit) state_in = S_IDLE;
               end
               default: begin
                  emit_go = can_emit;
                  if (can_emit) state_in = S_IDLE;
               end
            endcase
         end
         // Known-type table scan
         S_KRD: begin
            if (kidx_ff == kcnt_ff) begin
               // type not in table
               if (cmd_ff.command == CMD_REGISTER) begin
                  if (can_emit) begin
                     kt_we    = 1'b1;
                     kcnt_in  = kcnt_ff + 1'b1;
                     emit_go  = 1'b1;
                     state_in = S_IDLE;
                  end
               end else begin
                  emit_d.status = ST_BAD_HANDLER;
                  emit_go = can_emit;
                  if (can_emit) state_in = S_IDLE;
               end
            end else begin
               state_in = S_KCHK;
            end
         end
         S_KCHK: begin
            if (kt_rdata_ff == cmd_ff.req_type) begin
               if (cmd_ff.command == CMD_REGISTER) begin
                  emit_d.status = ST_DUPLICATE;
                  emit_go = can_emit;
                  if (can_emit) state_in = S_IDLE;
               end else if (cmd_ff.command == CMD_PUT_UNIQUE) begin
                  if (act_valid_ff && act_ff.etype == cmd_ff.req_type &&
                      act_ff.tag == cmd_ff.data_tag) begin
                     emit_go = can_emit;
                     if (can_emit) state_in = S_IDLE;
                  end else begin
                     state_in = S_QRD;
                  end
               end else begin
                  state_in = S_PUSH;
               end
            end else begin
               kidx_in  = kidx_ff + 1'b1;
               state_in = S_KRD;
            end
         end
         // Dedup scan over queued entries
         S_QRD: begin
            state_in = (idx_ff == len_ff) ? S_PUSH : S_QCHK;
         end
         S_QCHK: begin
            if (q_rdata_ff.etype == cmd_ff.req_type &&
                q_rdata_ff.tag == cmd_ff.data_tag) begin
               emit_go = can_emit;
               if (can_emit) state_in = S_IDLE;
            end else begin
               idx_in   = idx_ff + 1'b1;
               rptr_in  = ptr_inc(rptr_ff);
               state_in = S_QRD;
            end
         end
         S_PUSH: begin
            if (len_ff >= LW'(QUEUE_DEPTH)) begin
               emit_d.status = ST_BLOCKED;
               emit_go = can_emit;
               if (can_emit) state_in = S_IDLE;
            end else if (can_emit) begin
               q_we       = 1'b1;
               tail_in    = ptr_inc(tail_ff);
               len_in     = len_ff + 1'b1;
               pending_in = 1'b1;
               emit_go    = 1'b1;
               state_in   = S_IDLE;
            end
         end
         // Pop head into the active slot
         S_TAKE_RD: begin
            state_in = S_TAKE;
         end
         S_TAKE: begin
            if (can_emit) begin
               act_valid_in       = 1'b1;
               act_in             = q_rdata_ff;
               head_in            = ptr_inc(head_ff);
               len_in             = len_ff - 1'b1;
               emit_d.entry_valid = 1'b1;
               emit_d.entry_type  = q_rdata_ff.etype;
               emit_d.entry_data  = q_rdata_ff.tag;
               emit_go            = 1'b1;
               state_in           = S_IDLE;
            end
         end
         // Remove, first pass: count matches
         S_CRD: begin
            state_in = (idx_ff == len_ff) ? S_CEND : S_CCHK;
         end
         S_CCHK: begin
            if (q_rdata_ff.etype == cmd_ff.req_type) begin
               nrem_in = nrem_ff + 1'b1;
            end
            idx_in   = idx_ff + 1'b1;
            rptr_in  = ptr_inc(rptr_ff);
            state_in = S_CRD;
         end
         S_CEND: begin
            if (nrem_ff == '0) begin
               if (can_emit) begin
                  if (len_ff == '0 && !act_valid_ff) pending_in = 1'b0;
                  emit_go  = 1'b1;
                  state_in = S_IDLE;
               end
            end else begin
               if (len_ff == nrem_ff && !act_valid_ff) pending_in = 1'b0;
               idx_in   = '0;
               rptr_in  = head_ff;
               wptr_in  = head_ff;
               state_in = S_RRD;
            end
         end
         // Remove, second pass: emit matches, compact the rest
         S_RRD: begin
            if (idx_ff == len_ff) begin
               len_in   = len_ff - nrem_ff;
               tail_in  = wptr_ff;
               state_in = S_IDLE;
            end else begin
               state_in = S_RCHK;
            end
         end
         S_RCHK: begin
            if (q_rdata_ff.etype == cmd_ff.req_type) begin
               if (can_emit) begin
                  emit_d.entry_valid = 1'b1;
                  emit_d.entry_type  = q_rdata_ff.etype;
                  emit_d.entry_data  = q_rdata_ff.tag;
                  emit_d.item_count  = ITEM_W'(nrem_ff);
                  emit_d.last        = (LW'(ecnt_ff + 1'b1) == nrem_ff);
                  emit_go            = 1'b1;
                  ecnt_in            = ecnt_ff + 1'b1;
                  idx_in             = idx_ff + 1'b1;
                  rptr_in            = ptr_inc(rptr_ff);
                  state_in           = S_RRD;
               end
            end else begin
               q_we     = 1'b1;
               q_waddr  = wptr_ff;
               q_wdata  = q_rdata_ff;
               wptr_in  = ptr_inc(wptr_ff);
               idx_in   = idx_ff + 1'b1;
               rptr_in  = ptr_inc(rptr_ff);
               state_in = S_RRD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      emit_d.pending = pending_in;
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         len_ff       <= '0;
         kcnt_ff      <= '0;
         act_valid_ff <= 1'b0;
         act_ff       <= '0;
         pending_ff   <= 1'b0;
         blocked_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         len_ff       <= len_in;
         kcnt_ff      <= kcnt_in;
         act_valid_ff <= act_valid_in;
         act_ff       <= act_in;
         pending_ff   <= pending_in;
         if (csr_wr_en) begin
            blocked_ff <= csr_wr_data;
         end
         if (emit_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      cmd_ff  <= cmd_in;
      rptr_ff <= rptr_in;
      wptr_ff <= wptr_in;
      idx_ff  <= idx_in;
      nrem_ff <= nrem_in;
      ecnt_ff <= ecnt_in;
      kidx_ff <= kidx_in;
      if (emit_go) begin
         rsp_ff <= emit_d;
      end
   end

endmodule

>>> sv/rqd_checker.sv
// Port-level checks for request_queue_with_dedup_unit, attached by bind.
// Depends on rqd_pkg and the top level's ports.
module rqd_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  status,
   input logic        entry_valid,
   input logic [7:0]  entry_type,
   input logic [31:0] entry_data,
   input logic [4:0]  item_count,
   input logic        last
);
   import rqd_pkg::*;

   // A stalled response stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // Empty entry fields read as zero
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !entry_valid |-> entry_type == 8'd0 && entry_data == 32'd0)
      else $error("entry fields set without entry");

   // Error status is a single, entry-free result
   a_err_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status != ST_OK |-> !entry_valid && last)
      else $error("error result carries an entry or continues");

   // Only remove yields non-final results, each with an entry and a count
   a_multi: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !last |-> entry_valid && item_count != 5'd0)
      else $error("non-final result without removed entry");

endmodule

bind request_queue_with_dedup_unit rqd_checker u_rqd_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .status      (rsp_chan.payload.status),
   .entry_valid (rsp_chan.payload.entry_valid),
   .entry_type  (rsp_chan.payload.entry_type),
   .entry_data  (rsp_chan.payload.entry_data),
   .item_count  (rsp_chan.payload.item_count),
   .last        (rsp_chan.payload.last)
);
